[sv/cca_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar clock advance package
// Shared types, constants and calendar helper functions for the calendar
// clock advance block.
// ----------------------------------------------------------------------------
package cca_pkg;

    // Command codes carried by the cmd field.
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // Length of one day in milliseconds.
    localparam logic [31:0] DAY_MS = 32'd86400000;

    // Month lengths and the last month of the year.
    localparam logic [5:0] LEN_NONE  = 6'd0;
    localparam logic [5:0] LEN_LONG  = 6'd31;
    localparam logic [5:0] LEN_SHORT = 6'd30;
    localparam logic [5:0] LEN_FEB   = 6'd28;
    localparam logic [5:0] LEN_LEAP  = 6'd29;
    localparam logic [3:0] MONTHS    = 4'd12;
    localparam logic [3:0] WEEK_DAYS = 4'd7;

    // Divisibility by 25 of a 16-bit year: multiply by the inverse of 25
    // modulo 2^16; the product is small exactly for multiples of 25.
    localparam logic [15:0] YEAR_INV25     = 16'd23593;
    localparam logic [15:0] YEAR_DIV25_MAX = 16'd2621;

    // One input item as held in the input register.
    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [15:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [26:0] load_ms_of_day;
        logic [2:0]  load_weekday;
    } t_item;

    // Calendar state, which is also the reported result.
    typedef struct packed {
        logic [31:0] ms_of_day;
        logic [5:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic [2:0]  weekday;
    } t_cal;

    // Gregorian leap year: divisible by 4, and not by 100 unless by 400.
    // Divisible by 100 means by 4 and by 25; by 400 means by 16 and by 25.
    function automatic logic is_leap(input logic [15:0] year);
        logic [15:0] prod;
        logic        div25;
        prod  = year * YEAR_INV25;
        div25 = (prod <= YEAR_DIV25_MAX);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // Days in a month; zero for months that have no limit.
    function automatic logic [5:0] month_len(input logic [3:0] month,
                                             input logic [15:0] year);
        logic [5:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = LEN_SHORT;
            4'd2:    len = is_leap(year) ? LEN_LEAP : LEN_FEB;
            default: len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

[sv/calendar_clock_advance_core.sv]
// ----------------------------------------------------------------------------
// Calendar clock advance core
// Keeps a Gregorian calendar clock driven by a free-running millisecond
// timestamp, and reports the calendar after every item.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         i_in_valid / o_in_stall    i_cmd, i_now_ms, i_load_*
//   output   out        o_out_valid / i_out_stall  o_ms_of_day, o_day, o_month,
//                                                  o_year, o_weekday
//
// One item per cycle sustained while the output is not stalled; each result
// passes through the input register and then the calendar registers.
// The calendar registers double as the result register, so the state moves
// only when a result is loaded. Synchronous active-low reset clears the
// calendar and timestamp to zero. An output stall holds the result and
// backs up into the input register, which stalls the input once full.
// ----------------------------------------------------------------------------
module calendar_clock_advance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [26:0] i_load_ms_of_day,
    input  logic [2:0]  i_load_weekday,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_ms_of_day,
    output logic [5:0]  o_day,
    output logic [3:0]  o_month,
    output logic [15:0] o_year,
    output logic [2:0]  o_weekday
);
    import cca_pkg::*;

    logic        r_in_vld;
    t_item       r_item;
    logic        r_out_vld;
    t_cal        r_cal;
    logic [31:0] r_last;
    t_cal        n_cal;
    logic [31:0] n_last;
    logic        in_xfer;
    logic        out_xfer;
    logic        step;

    // Handshake: the item in the input register moves on when the result
    // register is empty or its result is being transferred out.
    assign step       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_vld && !i_out_stall;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.cmd            <= i_cmd;
            r_item.now_ms         <= i_now_ms;
            r_item.load_year      <= i_load_year;
            r_item.load_month     <= i_load_month;
            r_item.load_day       <= i_load_day;
            r_item.load_ms_of_day <= i_load_ms_of_day;
            r_item.load_weekday   <= i_load_weekday;
        end
    end

    // Calendar update logic.
    cca_next u_next (
        .i_item       (r_item),
        .i_cal        (r_cal),
        .i_last_stamp (r_last),
        .o_cal        (n_cal),
        .o_last_stamp (n_last)
    );

    // Calendar state and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_cal     <= '0;
            r_last    <= '0;
        end else begin
            if (step) begin
                r_out_vld <= 1'b1;
                r_cal     <= n_cal;
                r_last    <= n_last;
            end else if (out_xfer) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_ms_of_day = r_cal.ms_of_day;
    assign o_day       = r_cal.day;
    assign o_month     = r_cal.month;
    assign o_year      = r_cal.year;
    assign o_weekday   = r_cal.weekday;

    // The input is stalled only while the input register holds an item.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld)
        else $error("input stalled with empty input register");

    // An advance on an unset clock leaves the calendar untouched.
    a_unset_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_item.cmd == CMD_ADVANCE) && (r_cal.month == 4'd0))
        |=> (o_month == 4'd0) && $stable(o_ms_of_day) && $stable(o_day))
        else $error("unset clock changed on advance");

    // A load copies the requested date.
    a_load_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_item.cmd == CMD_LOAD))
        |=> (o_month == $past(r_item.load_month))
            && (o_year == $past(r_item.load_year)))
        else $error("load did not copy date");

    // Every advance records its timestamp; otherwise it is kept.
    a_stamp_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(step && (r_item.cmd == CMD_ADVANCE)) |=> $stable(r_last))
        else $error("timestamp changed without advance");

endmodule

[sv/cca_next.sv]
// ----------------------------------------------------------------------------
// Calendar next-state logic
// Computes the calendar and the stored timestamp that follow one item:
// a load copies the date and time, an advance adds elapsed milliseconds and
// performs at most one day rollover.
// ----------------------------------------------------------------------------
module cca_next (
    input  cca_pkg::t_item i_item,
    input  cca_pkg::t_cal  i_cal,
    input  logic [31:0]    i_last_stamp,
    output cca_pkg::t_cal  o_cal,
    output logic [31:0]    o_last_stamp
);
    import cca_pkg::*;

    logic [31:0] sum_ms;
    logic        day_done;
    logic [3:0]  wd_inc;
    logic [2:0]  wd_next;
    logic [5:0]  day_inc;
    logic [5:0]  lim;
    logic        mon_roll;
    logic [5:0]  day_next;
    logic [3:0]  mon_step;
    logic        yr_roll;

    // Elapsed time and the day rollover chain.
    always_comb begin
        sum_ms   = i_cal.ms_of_day + (i_item.now_ms - i_last_stamp);
        day_done = (sum_ms >= DAY_MS);

        wd_inc  = {1'b0, i_cal.weekday} + 4'd1;
        wd_next = (wd_inc >= WEEK_DAYS) ? 3'(wd_inc - WEEK_DAYS) : wd_inc[2:0];

        day_inc  = i_cal.day + 6'd1;
        lim      = month_len(i_cal.month, i_cal.year);
        mon_roll = (lim != LEN_NONE) && (day_inc > lim);
        day_next = mon_roll ? (day_inc - lim) : day_inc;
        mon_step = mon_roll ? (i_cal.month + 4'd1) : i_cal.month;
        yr_roll  = (mon_step > MONTHS);
    end

    // Select the update for the command.
    always_comb begin
        o_cal        = i_cal;
        o_last_stamp = i_last_stamp;
        if (i_item.cmd == CMD_LOAD) begin
            o_cal.year      = i_item.load_year;
            o_cal.month     = i_item.load_month;
            o_cal.day       = {1'b0, i_item.load_day};
            o_cal.ms_of_day = {5'd0, i_item.load_ms_of_day};
            o_cal.weekday   = i_item.load_weekday;
        end else begin
            o_last_stamp = i_item.now_ms;
            // An unset clock only tracks the timestamp.
            if (i_cal.month != 4'd0) begin
                o_cal.ms_of_day = sum_ms;
                if (day_done) begin
                    o_cal.ms_of_day = sum_ms - DAY_MS;
                    o_cal.weekday   = wd_next;
                    o_cal.day       = day_next;
                    o_cal.month     = yr_roll ? (mon_step - MONTHS) : mon_step;
                    o_cal.year      = yr_roll ? (i_cal.year + 16'd1) : i_cal.year;
                end
            end
        end
    end

endmodule
